[design/word_keyed_time_aggregator_unit_defines.svh]
// Assertion macros for the word keyed time aggregator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WORD_KEYED_TIME_AGGREGATOR_UNIT_DEFINES_SVH
`define WORD_KEYED_TIME_AGGREGATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WKTA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("wkta assertion failed");
`define WKTA_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("wkta assertion failed");
`else
`define WKTA_ASSERT_IMP(label, clk, rst_n, a, b)
`define WKTA_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

[design/wkta_pkg.sv]
// Types and constants shared by the word keyed time aggregator.
// No dependencies.
package wkta_pkg;

    localparam int SLOT_W     = 10;
    localparam int DIST_W     = 11;
    localparam int HASH_SHIFT = 5;
    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic [7:0]         text_byte;
        logic               end_of_text;
        logic signed [31:0] duration;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [63:0]        word_hash;
        logic signed [63:0] time_total;
        logic [31:0]        use_count;
        logic               was_truncated;
        logic               is_new;
        logic [DIST_W-1:0]  distinct_total;
        logic               table_full;
    } t_res;

    typedef struct packed {
        logic        valid;
        logic [63:0] hash;
        logic [63:0] time_total;
        logic [31:0] use_count;
        logic        truncated;
    } t_entry;

    typedef struct packed {
        logic [63:0] hash;
        logic        truncated;
    } t_fold;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

endpackage

[design/word_keyed_time_aggregator_unit.sv]
// Word keyed time aggregator: hashes the first word of each description and
// accumulates durations per hash in a linear-probed table. A byte that is not
// the last of its description is only folded into the hash. A final byte is
// accepted and then probes the table one slot at a time from its home slot,
// since the table memory has one read port with registered read data; up to
// 2^SLOT_INDEX_BITS slots are probed when the table is full. After reset a
// clearing pass writes every slot empty, during which no request is accepted.
`include "word_keyed_time_aggregator_unit_defines.svh"

module word_keyed_time_aggregator_unit #(
    parameter int SLOT_INDEX_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wkta_pkg::t_req   i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output wkta_pkg::t_res   o_out_res
);

    localparam int SLOT_COUNT = 1 << SLOT_INDEX_BITS;
    localparam int OCC_W      = SLOT_INDEX_BITS + 1;

    wkta_pkg::t_state r_state, n_state;
    wkta_pkg::t_fold  fold;
    wkta_pkg::t_entry rd, wdata;
    wkta_pkg::t_res   r_out, n_out;

    logic [SLOT_INDEX_BITS-1:0] r_clr_idx, r_idx, r_steps, raddr, waddr;
    logic [OCC_W-1:0]           r_occ, occ_next;
    logic [63:0]                r_key;
    logic                       r_trunc;
    logic signed [31:0]         r_dur;
    logic                       r_out_valid;
    logic                       accept, start, re, we, load_out;
    logic                       fresh, hit, last_step, out_free;
    logic [63:0]                dur_ext, new_time;
    logic [31:0]                new_count, idx_ext, home_ext, occ_ext, occn_ext;

    assign accept   = i_in_valid & o_in_ready;
    assign start    = accept & i_in_req.end_of_text;
    assign fresh    = !rd.valid;
    assign hit      = fresh || (rd.hash == r_key);
    assign last_step = (r_steps == '1);
    assign out_free = !r_out_valid || i_out_ready;

    assign dur_ext   = {{32{r_dur[31]}}, r_dur};
    assign new_time  = (fresh ? 64'd0 : rd.time_total) + dur_ext;
    assign new_count = (fresh ? 32'd0 : rd.use_count) + 32'd1;
    assign occ_next  = r_occ + OCC_W'(fresh);
    assign idx_ext   = 32'(r_idx);
    assign home_ext  = 32'(r_key[SLOT_INDEX_BITS-1:0]);
    assign occ_ext   = 32'(r_occ);
    assign occn_ext  = 32'(occ_next);

    wkta_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_req.text_byte),
        .i_last   (i_in_req.end_of_text),
        .o_fold   (fold)
    );

    wkta_table #(
        .INDEX_BITS (SLOT_INDEX_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wkta_pkg::S_CLEAR: begin
                if (r_clr_idx == '1) n_state = wkta_pkg::S_IDLE;
            end
            wkta_pkg::S_IDLE: begin
                if (start) n_state = wkta_pkg::S_PROBE;
            end
            wkta_pkg::S_PROBE: begin
                if ((hit || last_step) && out_free) n_state = wkta_pkg::S_IDLE;
            end
            default: n_state = wkta_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        re         = 1'b0;
        raddr      = r_idx + 1'b1;
        we         = 1'b0;
        waddr      = r_idx;
        wdata      = '0;
        load_out   = 1'b0;
        n_out      = '0;
        unique case (r_state)
            wkta_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_idx;
            end
            wkta_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                re         = start;
                raddr      = fold.hash[SLOT_INDEX_BITS-1:0];
            end
            wkta_pkg::S_PROBE: begin
                if (hit) begin
                    if (out_free) begin
                        we                   = 1'b1;
                        wdata.valid          = 1'b1;
                        wdata.hash           = r_key;
                        wdata.time_total     = new_time;
                        wdata.use_count      = new_count;
                        wdata.truncated      = (!fresh && rd.truncated) || r_trunc;
                        load_out             = 1'b1;
                        n_out.slot           = idx_ext[wkta_pkg::SLOT_W-1:0];
                        n_out.word_hash      = r_key;
                        n_out.time_total     = new_time;
                        n_out.use_count      = new_count;
                        n_out.was_truncated  = wdata.truncated;
                        n_out.is_new         = fresh;
                        n_out.distinct_total = occn_ext[wkta_pkg::DIST_W-1:0];
                    end
                end else if (last_step) begin
                    if (out_free) begin
                        load_out             = 1'b1;
                        n_out.slot           = home_ext[wkta_pkg::SLOT_W-1:0];
                        n_out.word_hash      = r_key;
                        n_out.distinct_total = occ_ext[wkta_pkg::DIST_W-1:0];
                        n_out.table_full     = 1'b1;
                    end
                end else begin
                    re = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wkta_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wkta_pkg::S_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (we && r_state == wkta_pkg::S_PROBE) r_occ <= occ_next;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_key   <= fold.hash;
            r_trunc <= fold.truncated;
            r_dur   <= i_in_req.duration;
            r_idx   <= fold.hash[SLOT_INDEX_BITS-1:0];
            r_steps <= '0;
        end else if (r_state == wkta_pkg::S_PROBE && re) begin
            r_idx   <= r_idx + 1'b1;
            r_steps <= r_steps + 1'b1;
        end
        if (load_out) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `WKTA_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, we, !re)
    `WKTA_ASSERT_NXT(a_start_probes, i_clk, i_rst_n, start, r_state == wkta_pkg::S_PROBE)
    `WKTA_ASSERT_IMP(a_full_empty, i_clk, i_rst_n, o_out_valid && o_out_res.table_full,
        !o_out_res.is_new && o_out_res.use_count == 32'd0)
    `WKTA_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == wkta_pkg::S_CLEAR,
        !o_out_valid && !o_in_ready)
    `WKTA_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(SLOT_COUNT))

endmodule

[design/wkta_hash.sv]
// Running djb2 hash over the first word of a description.
// Depends on wkta_pkg.
module wkta_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output wkta_pkg::t_fold    o_fold
);

    logic [63:0] r_hash;
    logic        r_past;
    logic [63:0] n_hash;
    logic        is_space;

    assign is_space = (i_byte == wkta_pkg::SPACE_CHAR);

    always_comb begin
        if (is_space || r_past) begin
            n_hash = r_hash;
        end else begin
            n_hash = (r_hash << wkta_pkg::HASH_SHIFT) + r_hash + 64'(i_byte);
        end
    end

    assign o_fold.hash      = n_hash;
    assign o_fold.truncated = r_past | is_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= wkta_pkg::HASH_SEED;
            r_past <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hash <= wkta_pkg::HASH_SEED;
                r_past <= 1'b0;
            end else begin
                r_hash <= n_hash;
                r_past <= r_past | is_space;
            end
        end
    end

endmodule

[design/wkta_table.sv]
// Slot table: one write port, one read port, registered read data.
// Depends on wkta_pkg.
module wkta_table #(
    parameter int INDEX_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [INDEX_BITS-1:0]  i_waddr,
    input  wkta_pkg::t_entry       i_wdata,
    input  logic                   i_re,
    input  logic [INDEX_BITS-1:0]  i_raddr,
    output wkta_pkg::t_entry       o_rdata
);

    localparam int DEPTH = 1 << INDEX_BITS;

    wkta_pkg::t_entry mem [DEPTH];
    wkta_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/word_keyed_time_aggregator_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for word_keyed_time_aggregator_unit: a queue-fed request driver,
// a result monitor and a shadow hash table that predicts every slot update.
// Depends on wkta_pkg and the aggregator RTL.
module word_keyed_time_aggregator_unit_test;

    localparam int SLOTS         = 1 << wkta_pkg::SLOT_W;
    localparam int VOCAB         = 48;
    localparam int RANDOM_BYTES  = 1000;
    localparam int ZERO_WORD_LEN = 14;
    localparam int FILL_LEN      = 2;
    localparam int SETTLE_CYCLES = SLOTS + 64;

    bit   i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    wkta_pkg::t_req i_in_req = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    wkta_pkg::t_res o_out_res;

    wkta_pkg::t_req pending_bytes [$];
    wkta_pkg::t_res expected_updates [$];
    int   bytes_queued;
    int   failures;
    bit   calm;

    logic              slot_used  [SLOTS] = '{default: 1'b0};
    logic [63:0]       slot_key   [SLOTS] = '{default: '0};
    logic [63:0]       slot_sum   [SLOTS] = '{default: '0};
    logic [31:0]       slot_uses  [SLOTS] = '{default: '0};
    logic              slot_trunc [SLOTS] = '{default: 1'b0};
    logic [63:0]       fold_hash  = wkta_pkg::HASH_SEED;
    logic              fold_space = 1'b0;
    logic [wkta_pkg::DIST_W-1:0] occupied = '0;

    logic [7:0] vocab_bytes [VOCAB][6];
    int         vocab_len   [VOCAB];

    word_keyed_time_aggregator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 18);
    endfunction

    function automatic logic [7:0] nonspace_byte();
        logic [7:0] b;
        b = 8'($urandom_range(254));
        if (b >= wkta_pkg::SPACE_CHAR) b++;
        return b;
    endfunction

    // Shadow of the block: folds one accepted request and, for a final byte, predicts the slot update.
    function automatic void tally_byte(wkta_pkg::t_req r);
        logic [wkta_pkg::SLOT_W-1:0] home;
        logic [wkta_pkg::SLOT_W-1:0] idx;
        logic              hit;
        logic              fresh;
        logic [63:0]       dur64;
        wkta_pkg::t_res    e;
        int                n;
        if (r.text_byte == wkta_pkg::SPACE_CHAR) fold_space = 1'b1;
        else if (!fold_space) fold_hash = fold_hash * 64'd33 + 64'(r.text_byte);
        if (!r.end_of_text) return;

        dur64 = {{32{r.duration[31]}}, r.duration};
        home  = fold_hash[wkta_pkg::SLOT_W-1:0];
        idx   = home;
        hit   = 1'b0;
        fresh = 1'b0;
        for (n = 0; n < SLOTS && !hit; n++) begin
            if (!slot_used[idx]) begin
                hit   = 1'b1;
                fresh = 1'b1;
            end else if (slot_key[idx] == fold_hash) begin
                hit = 1'b1;
            end else begin
                idx = idx + 1'b1;
            end
        end

        e = '0;
        e.word_hash = fold_hash;
        if (hit) begin
            if (fresh) begin
                slot_used[idx]  = 1'b1;
                slot_key[idx]   = fold_hash;
                slot_sum[idx]   = '0;
                slot_uses[idx]  = '0;
                slot_trunc[idx] = 1'b0;
                occupied++;
            end
            if (fold_space) slot_trunc[idx] = 1'b1;
            slot_sum[idx]  = slot_sum[idx] + dur64;
            slot_uses[idx] = slot_uses[idx] + 32'd1;
            e.slot          = idx;
            e.time_total    = slot_sum[idx];
            e.use_count     = slot_uses[idx];
            e.was_truncated = slot_trunc[idx];
            e.is_new        = fresh;
        end else begin
            e.slot       = home;
            e.table_full = 1'b1;
        end
        e.distinct_total = occupied;
        expected_updates.push_back(e);

        fold_hash  = wkta_pkg::HASH_SEED;
        fold_space = 1'b0;
    endfunction

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
        end
    endtask

    task automatic push_request(logic [7:0] b, logic last);
        wkta_pkg::t_req r;
        r.text_byte   = b;
        r.end_of_text = last;
        case ($urandom_range(11))
            0:       r.duration = 32'sh7FFFFFFF;
            1:       r.duration = 32'sh80000000;
            2:       r.duration = '0;
            3:       r.duration = '1;
            default: r.duration = $urandom();
        endcase
        pending_bytes.push_back(r);
        bytes_queued++;
    endtask

    // Builds a word whose hash is zero modulo 2^64: base-33 digits of a preimage,
    // retried over multiples of 2^64 until no digit is a space.
    task automatic queue_zero_hash_word();
        logic [127:0] s;
        logic [63:0]  pw;
        logic [63:0]  t;
        logic [7:0]   digit [ZERO_WORD_LEN];
        bit           ok;
        int           m;
        int           j;
        pw = 64'd1;
        for (j = 0; j < ZERO_WORD_LEN; j++) pw = pw * 64'd33;
        t  = 64'd0 - wkta_pkg::HASH_SEED * pw;
        ok = 1'b0;
        for (m = 0; m < 100 && !ok; m++) begin
            s  = {64'(m), t};
            ok = 1'b1;
            for (j = ZERO_WORD_LEN - 1; j >= 0; j--) begin
                digit[j] = 8'(s % 128'd33);
                if (digit[j] == wkta_pkg::SPACE_CHAR) ok = 1'b0;
                s = s / 128'd33;
            end
            if (s != 0) ok = 1'b0;
        end
        for (j = 0; j < ZERO_WORD_LEN; j++) push_request(digit[j], j == ZERO_WORD_LEN - 1);
    endtask

    task automatic queue_description();
        int w;
        int len;
        int tail;
        int k;
        if ($urandom_range(99) < 70) begin
            w    = $urandom_range(VOCAB - 1);
            len  = vocab_len[w];
            tail = ($urandom_range(99) < 30) ? $urandom_range(1, 5) : 0;
            for (k = 0; k < len; k++) push_request(vocab_bytes[w][k], k == len - 1 && tail == 0);
            for (k = 0; k < tail; k++) begin
                push_request((k == 0) ? wkta_pkg::SPACE_CHAR : 8'($urandom_range(255)),
                             k == tail - 1);
            end
        end else begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) push_request(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_updates.size() != 0);
    endtask

    always @(posedge i_clk) begin
        logic next_valid;
        wkta_pkg::t_req next_req;
        next_valid = i_in_valid;
        next_req   = i_in_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tally_byte(i_in_req);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_bytes.size() != 0 && !take_break()) begin
                next_req   = pending_bytes.pop_front();
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
            i_in_req   <= next_req;
        end
    end

    always @(posedge i_clk) begin
        wkta_pkg::t_res want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0h", $time, o_out_res);
                    failures++;
                end else begin
                    want = expected_updates.pop_front();
                    compare_field("slot", 64'(want.slot), 64'(o_out_res.slot));
                    compare_field("word_hash", want.word_hash, o_out_res.word_hash);
                    compare_field("time_total", want.time_total, o_out_res.time_total);
                    compare_field("use_count", 64'(want.use_count), 64'(o_out_res.use_count));
                    compare_field("was_truncated", 64'(want.was_truncated),
                                  64'(o_out_res.was_truncated));
                    compare_field("is_new", 64'(want.is_new), 64'(o_out_res.is_new));
                    compare_field("distinct_total", 64'(want.distinct_total),
                                  64'(o_out_res.distinct_total));
                    compare_field("table_full", 64'(want.table_full), 64'(o_out_res.table_full));
                end
            end
            i_out_ready <= !take_break();
        end
    end

    initial begin
        int         w;
        int         k;
        int         start;
        int         need;
        bit         zero_again;
        logic [7:0] fill_word [FILL_LEN];
        zero_again = 1'b0;
        for (w = 0; w < VOCAB; w++) begin
            vocab_len[w] = $urandom_range(1, 6);
            for (k = 0; k < 6; k++) vocab_bytes[w][k] = nonspace_byte();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_request(8'h00, 1'b1);
        push_request(8'hFF, 1'b1);
        push_request(8'hFF, 1'b1);
        push_request(wkta_pkg::SPACE_CHAR, 1'b1);
        push_request(8'h61, 1'b0);
        push_request(wkta_pkg::SPACE_CHAR, 1'b0);
        push_request(8'h63, 1'b1);
        push_request(8'h61, 1'b1);
        queue_zero_hash_word();
        wait_drained();

        start = bytes_queued;
        while (bytes_queued - start < RANDOM_BYTES) begin
            while (pending_bytes.size() > 8) @(negedge i_clk);
            calm = (bytes_queued - start >= 350) && (bytes_queued - start < 650);
            if (!zero_again && bytes_queued - start >= 500) begin
                queue_zero_hash_word();
                zero_again = 1'b1;
            end
            queue_description();
        end
        calm = 1'b0;

        // fill every slot, never past full, so the probe wraps and clusters
        wait_drained();
        while (occupied != SLOTS) begin
            need = SLOTS - occupied;
            repeat (need) begin
                for (k = 0; k < FILL_LEN; k++) fill_word[k] = nonspace_byte();
                for (k = 0; k < FILL_LEN; k++) push_request(fill_word[k], k == FILL_LEN - 1);
            end
            wait_drained();
        end

        // full table: known words still hit, new words report full
        for (k = 0; k < FILL_LEN; k++) push_request(fill_word[k], k == FILL_LEN - 1);
        repeat (4) begin
            for (k = 0; k < 5; k++) push_request(nonspace_byte(), k == 4);
        end
        push_request(nonspace_byte(), 1'b0);
        push_request(wkta_pkg::SPACE_CHAR, 1'b0);
        push_request(nonspace_byte(), 1'b1);
        queue_zero_hash_word();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
